### rtl/atl_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the ADC breakpoint table for the temperature linearizer.
// No dependencies.
package atl_pkg;

  localparam int ADC_BITS     = 10;
  localparam int FRAC_BITS    = 8;
  localparam int TABLE_POINTS = 66;
  localparam int TEMP_BITS    = 16;
  localparam int IDX_BITS     = $clog2(TABLE_POINTS);
  localparam int CNT_BITS     = $clog2(FRAC_BITS + 1);

  typedef logic [ADC_BITS-1:0]         level_t;
  typedef logic [IDX_BITS-1:0]         idx_t;
  typedef logic [FRAC_BITS-1:0]        frac_t;
  typedef logic [CNT_BITS-1:0]         cnt_t;
  typedef logic signed [TEMP_BITS-1:0] temp_t;

  typedef enum logic [1:0] {
    RANGE_IN    = 2'd0,
    RANGE_BELOW = 2'd1,
    RANGE_ABOVE = 2'd2
  } range_t;

  localparam level_t LEVEL_POINTS [TABLE_POINTS] = '{
    10'd142, 10'd144, 10'd147, 10'd152, 10'd159, 10'd164, 10'd170, 10'd176, 10'd184, 10'd190,
    10'd198, 10'd205, 10'd212, 10'd219, 10'd226, 10'd232, 10'd241, 10'd250, 10'd258, 10'd266,
    10'd276, 10'd285, 10'd296, 10'd306, 10'd318, 10'd327, 10'd337, 10'd347, 10'd360, 10'd375,
    10'd388, 10'd400, 10'd412, 10'd428, 10'd442, 10'd454, 10'd466, 10'd480, 10'd495, 10'd513,
    10'd527, 10'd540, 10'd554, 10'd569, 10'd583, 10'd600, 10'd615, 10'd630, 10'd646, 10'd660,
    10'd676, 10'd692, 10'd711, 10'd729, 10'd746, 10'd766, 10'd782, 10'd804, 10'd823, 10'd843,
    10'd862, 10'd882, 10'd900, 10'd920, 10'd942, 10'd961
  };

  localparam level_t FIRST_POINT = LEVEL_POINTS[0];
  localparam level_t LAST_POINT  = LEVEL_POINTS[TABLE_POINTS-1];
  localparam idx_t   LAST_IDX    = idx_t'(TABLE_POINTS - 1);

  localparam temp_t TEMP_BELOW = -temp_t'(1 << FRAC_BITS);
  localparam temp_t TEMP_ABOVE = temp_t'(TABLE_POINTS << FRAC_BITS);
  localparam temp_t TEMP_LAST  = temp_t'((TABLE_POINTS - 1) << FRAC_BITS);

  function automatic level_t point_at(idx_t k);
    return (k < LAST_IDX + idx_t'(1)) ? LEVEL_POINTS[k] : '0;
  endfunction

endpackage

### rtl/atl_search.sv
`timescale 1ns / 1ps
// Bit-serial search for the table segment holding a level, one index bit per cycle.
// Depends on atl_pkg.
module atl_search (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  atl_pkg::level_t level,
  output atl_pkg::idx_t   idx,
  output logic            done
);

  atl_pkg::idx_t   probe;
  atl_pkg::idx_t   cand;
  atl_pkg::level_t lvl;
  logic            busy;
  logic            take;

  assign cand = idx | probe;
  assign take = (cand < atl_pkg::LAST_IDX) && (atl_pkg::point_at(cand) <= lvl);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        idx   <= '0;
        probe <= atl_pkg::idx_t'(1) << (atl_pkg::IDX_BITS - 1);
        lvl   <= level;
      end else if (busy) begin
        if (take) begin
          idx <= cand;
        end
        probe <= probe >> 1;
        if (probe[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/atl_div.sv
`timescale 1ns / 1ps
// Restoring divider giving (num << FRAC_BITS) / den one quotient bit per cycle; num < den.
// Depends on atl_pkg.
module atl_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  atl_pkg::level_t num,
  input  atl_pkg::level_t den,
  output atl_pkg::frac_t  quot,
  output logic            done
);

  atl_pkg::level_t                 rem;
  atl_pkg::level_t                 dv;
  atl_pkg::cnt_t                   cnt;
  logic [atl_pkg::ADC_BITS:0]      trial;
  logic                            ge;

  assign trial = {rem, 1'b0};
  assign ge    = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= num;
        dv   <= den;
        quot <= '0;
        cnt  <= atl_pkg::cnt_t'(atl_pkg::FRAC_BITS);
      end else if (cnt != '0) begin
        rem  <= ge ? atl_pkg::level_t'(trial - {1'b0, dv}) : atl_pkg::level_t'(trial);
        quot <= atl_pkg::frac_t'({quot, ge});
        cnt  <= cnt - atl_pkg::cnt_t'(1);
        if (cnt == atl_pkg::cnt_t'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/adc_temperature_linearizer_top.sv
`timescale 1ns / 1ps
// Top level of the ADC temperature linearizer: filter, control and output register.
// Depends on atl_pkg, atl_search and atl_div.
//
// Usage:
//   Input channel: adc_sample with in_valid / in_stall. One beat per ADC reading.
//   Output channel: temperature (degC, 8 fractional bits), filtered_level and
//   range_status with out_valid / out_stall. Exactly one output beat per input beat.
//   A sample is averaged with the previous level (a stored level of zero means
//   unseeded), then looked up in the breakpoint table and interpolated.
//   Levels at or below the first table point, above the last point, or on the last
//   point go straight from idle to the output hand-off. Other levels pass a 7-step
//   serial index search, an 8-step serial divider and the hand-off to the output register.
//   in_stall is high while an item is in progress, so one item is worked at a time
//   and a new beat is taken only once the last one has reached the output register.
//   While out_stall holds a result in the output register a new beat is still taken
//   and worked; it waits at the end of its computation until the register frees.
//   Reset (rst, synchronous) empties the output register, returns to idle and
//   clears the stored level to the unseeded state.
module adc_temperature_linearizer_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [atl_pkg::ADC_BITS-1:0]        adc_sample,
  input  logic                                in_valid,
  output logic                                in_stall,
  output logic signed [atl_pkg::TEMP_BITS-1:0] temperature,
  output logic [atl_pkg::ADC_BITS-1:0]        filtered_level,
  output logic [1:0]                          range_status,
  output logic                                out_valid,
  input  logic                                out_stall
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DIV,
    S_DONE
  } state_t;

  state_t                       state;
  atl_pkg::level_t              smoothed;
  atl_pkg::level_t              prev;
  atl_pkg::level_t              level_next;
  logic [atl_pkg::ADC_BITS:0]   sum;
  atl_pkg::idx_t                seg_idx;
  atl_pkg::temp_t               res_temp;
  atl_pkg::range_t              res_range;
  logic                         in_acc;
  logic                         out_free;
  logic                         srch_start;
  logic                         srch_done;
  atl_pkg::idx_t                srch_idx;
  atl_pkg::level_t              seg_lo;
  atl_pkg::level_t              seg_hi;
  atl_pkg::level_t              span;
  atl_pkg::level_t              div_num;
  atl_pkg::level_t              div_den;
  logic                         div_start;
  logic                         div_done;
  atl_pkg::frac_t               div_quot;

  assign in_stall   = (state != S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;

  assign prev       = (smoothed == '0) ? adc_sample : smoothed;
  assign sum        = {1'b0, prev} + {1'b0, adc_sample};
  assign level_next = sum[atl_pkg::ADC_BITS:1];

  assign srch_start = in_acc && (level_next > atl_pkg::FIRST_POINT) &&
                      (level_next < atl_pkg::LAST_POINT);

  assign seg_lo     = atl_pkg::point_at(srch_idx);
  assign seg_hi     = atl_pkg::point_at(srch_idx + atl_pkg::idx_t'(1));
  assign span       = seg_hi - seg_lo;
  assign div_den    = (span == '0) ? atl_pkg::level_t'(1) : span;
  assign div_num    = smoothed - seg_lo;
  assign div_start  = (state == S_SEARCH) && srch_done;

  atl_search u_search (
    .clk   (clk),
    .rst   (rst),
    .start (srch_start),
    .level (level_next),
    .idx   (srch_idx),
    .done  (srch_done)
  );

  atl_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (div_quot),
    .done  (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      smoothed  <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            smoothed <= level_next;
            if (level_next > atl_pkg::LAST_POINT) begin
              res_temp  <= atl_pkg::TEMP_ABOVE;
              res_range <= atl_pkg::RANGE_ABOVE;
              state     <= S_DONE;
            end else if (level_next <= atl_pkg::FIRST_POINT) begin
              res_temp  <= atl_pkg::TEMP_BELOW;
              res_range <= atl_pkg::RANGE_BELOW;
              state     <= S_DONE;
            end else if (level_next == atl_pkg::LAST_POINT) begin
              res_temp  <= atl_pkg::TEMP_LAST;
              res_range <= atl_pkg::RANGE_IN;
              state     <= S_DONE;
            end else begin
              res_range <= atl_pkg::RANGE_IN;
              state     <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (srch_done) begin
            seg_idx <= srch_idx;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            res_temp <= atl_pkg::temp_t'({seg_idx, div_quot});
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            temperature    <= res_temp;
            filtered_level <= smoothed;
            range_status   <= res_range;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/atl_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the temperature linearizer, bound to the top level.
// Depends on atl_pkg and adc_temperature_linearizer_top.
module atl_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic [atl_pkg::ADC_BITS-1:0]         adc_sample,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic signed [atl_pkg::TEMP_BITS-1:0] temperature,
  input logic [atl_pkg::ADC_BITS-1:0]         filtered_level,
  input logic [1:0]                           range_status,
  input logic                                 out_valid,
  input logic                                 out_stall
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(temperature) && $stable(filtered_level) &&
                               $stable(range_status))
    else $error("stalled output beat changed");

  a_below: assert property (@(posedge clk) disable iff (rst)
    out_valid && (range_status == atl_pkg::RANGE_BELOW) |->
      (temperature == atl_pkg::TEMP_BELOW) && (filtered_level <= atl_pkg::FIRST_POINT))
    else $error("below-table beat inconsistent");

  a_above: assert property (@(posedge clk) disable iff (rst)
    out_valid && (range_status == atl_pkg::RANGE_ABOVE) |->
      (temperature == atl_pkg::TEMP_ABOVE) && (filtered_level > atl_pkg::LAST_POINT))
    else $error("above-table beat inconsistent");

  a_within: assert property (@(posedge clk) disable iff (rst)
    out_valid && (range_status == atl_pkg::RANGE_IN) |->
      (filtered_level > atl_pkg::FIRST_POINT) && (filtered_level <= atl_pkg::LAST_POINT) &&
      (temperature >= 0) && (temperature <= atl_pkg::TEMP_LAST))
    else $error("in-table beat out of range");

endmodule

bind adc_temperature_linearizer_top atl_checker u_atl_checker (.*);

### verif/adc_temperature_linearizer_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for adc_temperature_linearizer_top: drives ADC beats and
// predicts each filtered level, range and interpolated temperature. Uses atl_pkg.
module adc_temperature_linearizer_top_test;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 40;
  localparam int ITEM_TARGET    = 560;

  typedef struct packed {
    atl_pkg::temp_t  temp;
    atl_pkg::level_t level;
    atl_pkg::range_t status;
  } reading_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  atl_pkg::level_t adc_sample = '0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  atl_pkg::temp_t  temperature;
  atl_pkg::level_t filtered_level;
  logic [1:0]      range_status;
  logic            out_valid;
  logic            out_stall = 1'b0;

  reading_t        reading_q[$];
  atl_pkg::level_t held_level = '0;
  bit       tx_idle = 1'b1;
  bit       rx_idle = 1'b1;
  int       hold_cycles = 0;
  int       items_sent = 0;
  int       results_seen = 0;
  int       faults = 0;
  int       quiet_cycles = 0;
  int       range_hits[3] = '{0, 0, 0};

  adc_temperature_linearizer_top u_dut (
    .clk            (clk),
    .rst            (rst),
    .adc_sample     (adc_sample),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .temperature    (temperature),
    .filtered_level (filtered_level),
    .range_status   (range_status),
    .out_valid      (out_valid),
    .out_stall      (out_stall)
  );

  always #5 clk = ~clk;

  // Averaging filter followed by table lookup; updates the held level.
  function automatic reading_t linearize(atl_pkg::level_t sample);
    int       scale;
    int       prev;
    int       seg;
    int       lo;
    int       hi;
    reading_t r;
    scale = 1 << atl_pkg::FRAC_BITS;
    prev = (held_level == '0) ? int'(sample) : int'(held_level);
    r.level = atl_pkg::level_t'((prev + int'(sample)) / 2);
    held_level = r.level;
    if (r.level > atl_pkg::LEVEL_POINTS[atl_pkg::TABLE_POINTS-1]) begin
      r.temp = atl_pkg::temp_t'(atl_pkg::TABLE_POINTS * scale);
      r.status = atl_pkg::RANGE_ABOVE;
    end else if (r.level <= atl_pkg::LEVEL_POINTS[0]) begin
      r.temp = atl_pkg::temp_t'(-scale);
      r.status = atl_pkg::RANGE_BELOW;
    end else if (r.level == atl_pkg::LEVEL_POINTS[atl_pkg::TABLE_POINTS-1]) begin
      r.temp = atl_pkg::temp_t'((atl_pkg::TABLE_POINTS - 1) * scale);
      r.status = atl_pkg::RANGE_IN;
    end else begin
      seg = 1;
      while (seg < atl_pkg::TABLE_POINTS - 1 && r.level >= atl_pkg::LEVEL_POINTS[seg]) seg++;
      lo = int'(atl_pkg::LEVEL_POINTS[seg-1]);
      hi = int'(atl_pkg::LEVEL_POINTS[seg]);
      r.temp = atl_pkg::temp_t'((seg - 1) * scale +
                                ((int'(r.level) - lo) * scale) / (hi - lo));
      r.status = atl_pkg::RANGE_IN;
    end
    return r;
  endfunction

  task automatic flag_fault(string what);
    faults++;
    if (faults <= 10) $display("ERROR: %s", what);
  endtask

  task automatic send_sample(input atl_pkg::level_t sample);
    if (tx_idle && $urandom_range(0, 99) < 38) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    adc_sample <= sample;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    reading_q.push_back(linearize(sample));
    items_sent++;
  endtask

  // Feeds samples until the filtered level lands on the target, giving up after 16 tries.
  task automatic steer_level(input int target);
    int cur;
    int tries;
    tries = 0;
    do begin
      cur = (held_level == '0) ? target : 2 * target - int'(held_level);
      if (cur < 0) cur = 0;
      if (cur > 1023) cur = 1023;
      send_sample(atl_pkg::level_t'(cur));
      tries++;
    end while (int'(held_level) != target && tries < 16);
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    do @(posedge clk); while (reading_q.size() != 0);
  endtask

  task automatic random_item;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      send_sample(atl_pkg::level_t'($urandom_range(0, 1023)));
    end else if (pick < 75) begin
      steer_level(int'(atl_pkg::LEVEL_POINTS[$urandom_range(0, atl_pkg::TABLE_POINTS - 1)]) +
                  $urandom_range(0, 2) - 1);
    end else if (pick < 85) begin
      send_sample($urandom_range(0, 1) ? atl_pkg::level_t'($urandom_range(0, 3))
                                       : atl_pkg::level_t'($urandom_range(1020, 1023)));
    end else if (pick < 93) begin
      steer_level($urandom_range(143, 960));
    end else begin
      steer_level(0);
      send_sample('0);
    end
  endtask

  task automatic test_unseeded_zero;
    send_sample('0);
    send_sample('0);
    send_sample(10'd1023);
    send_sample(10'd1023);
  endtask

  task automatic test_table_edges;
    int targets[9] = '{961, 962, 960, 142, 143, 141, 144, 1, 0};
    foreach (targets[k]) steer_level(targets[k]);
    send_sample('0);
    send_sample(10'd5);
  endtask

  task automatic test_random_samples;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    repeat (80) random_item();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    while (items_sent < ITEM_TARGET) random_item();
  endtask

  task automatic test_output_hold;
    wait_drained();
    tx_idle = 1'b0;
    hold_cycles = HOLD_CYCLES;
    repeat (6) send_sample(atl_pkg::level_t'($urandom_range(0, 1023)));
    tx_idle = 1'b1;
    wait_drained();
  endtask

  task automatic test_drain_pause;
    repeat (5) random_item();
    wait_drained();
    repeat (8) random_item();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else if (rx_idle) begin
      out_stall <= ($urandom_range(0, 99) < 38);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_beats
    reading_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      results_seen++;
      if (range_status < 2'd3) range_hits[range_status]++;
      if (reading_q.size() == 0) begin
        flag_fault($sformatf("unexpected beat: temp=%0d level=%0d range=%0d",
                             $signed(temperature), filtered_level, range_status));
      end else begin
        want = reading_q.pop_front();
        if (temperature !== want.temp || filtered_level !== want.level ||
            range_status !== want.status)
          flag_fault($sformatf(
            "beat %0d: expected temp=%0d level=%0d range=%0d, got temp=%0d level=%0d range=%0d",
            results_seen, $signed(want.temp), want.level, want.status,
            $signed(temperature), filtered_level, range_status));
      end
    end
  end

  always @(posedge clk) begin
    if (in_valid && !in_stall) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no input beat for %0d cycles, %0d readings outstanding",
                 quiet_cycles, reading_q.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_unseeded_zero();
    test_table_edges();
    test_random_samples();
    test_output_hold();
    test_drain_pause();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d samples, checked %0d readings (%0d in table, %0d below, %0d above).",
             items_sent, results_seen, range_hits[atl_pkg::RANGE_IN],
             range_hits[atl_pkg::RANGE_BELOW], range_hits[atl_pkg::RANGE_ABOVE]);
    $display("Covered filter seeding, table edges and points, output hold-off; %0d faults.",
             faults);
    if (faults == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/atl_pkg.sv
rtl/atl_search.sv
rtl/atl_div.sv
rtl/adc_temperature_linearizer_top.sv
rtl/atl_checker.sv
verif/adc_temperature_linearizer_top_test.sv
